// ===== rtl/c6502ex_pkg.sv =====
package c6502ex_pkg;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned IN_W     = 24;
	localparam int unsigned OUT_W    = 80;
	localparam int unsigned ZP_DEPTH = 256;
	localparam int unsigned ZP_AW    = 8;

	// Fixed addresses
	localparam logic [WORD_W-1:0] PC_RESET   = 16'hFFFC;
	localparam logic [WORD_W-1:0] STACK_BASE = 16'h0100;

	// Write kind codes
	localparam logic [KIND_W-1:0] WK_NONE = 2'd0;
	localparam logic [KIND_W-1:0] WK_BYTE = 2'd1;
	localparam logic [KIND_W-1:0] WK_WORD = 2'd2;

	// Supported opcodes
	localparam logic [BYTE_W-1:0] OP_AND_IMM = 8'h29;
	localparam logic [BYTE_W-1:0] OP_LDA_IMM = 8'hA9;
	localparam logic [BYTE_W-1:0] OP_LDA_ZP  = 8'hA5;
	localparam logic [BYTE_W-1:0] OP_LDA_ZPX = 8'hB5;
	localparam logic [BYTE_W-1:0] OP_LDX_IMM = 8'hA2;
	localparam logic [BYTE_W-1:0] OP_LDX_ZP  = 8'hA6;
	localparam logic [BYTE_W-1:0] OP_LDY_IMM = 8'hA0;
	localparam logic [BYTE_W-1:0] OP_LDY_ZP  = 8'hA4;
	localparam logic [BYTE_W-1:0] OP_NOP     = 8'hEA;
	localparam logic [BYTE_W-1:0] OP_STA_ZP  = 8'h85;
	localparam logic [BYTE_W-1:0] OP_STA_ZPX = 8'h95;
	localparam logic [BYTE_W-1:0] OP_STX_ZP  = 8'h86;
	localparam logic [BYTE_W-1:0] OP_STX_ZPY = 8'h96;
	localparam logic [BYTE_W-1:0] OP_STY_ZP  = 8'h84;
	localparam logic [BYTE_W-1:0] OP_STY_ZPX = 8'h94;
	localparam logic [BYTE_W-1:0] OP_STX_ABS = 8'h8E;
	localparam logic [BYTE_W-1:0] OP_STY_ABS = 8'h8C;
	localparam logic [BYTE_W-1:0] OP_JSR     = 8'h20;

	// Architectural registers
	typedef struct packed {
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] y;
		logic              z;
		logic              n;
		logic [WORD_W-1:0] pc;
	} arch_t;

	// Byte write into the zero-page store
	typedef struct packed {
		logic             we;
		logic [ZP_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} zp_wr_t;

	// Memory write report and status of one instruction
	typedef struct packed {
		logic [KIND_W-1:0] write_kind;
		logic [WORD_W-1:0] write_address;
		logic [WORD_W-1:0] write_data;
		logic              unsupported;
	} exec_rpt_t;

endpackage

// ===== rtl/cpu6502_subset_execute_core.sv =====
// Executes one instruction of a small 6502 subset per item.
// Input channel s_axis: one item is a whole instruction (opcode and two
// operand bytes, unused bytes ignored). Output channel m_axis: one item per
// instruction with A, X, Y, Z, N, the next program counter, the memory write
// it made (none, byte or little-endian word) and an unsupported-opcode flag.
// The zero-page read is issued at the accepting edge, together with the input
// stage register; the execute stage then fills the output register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the execute stage and the one read port of the zero-page memory;
// a store and a following load of the same address are forwarded.
// Reset clears A, X, Y and the flags, sets the program counter to 0xFFFC and
// marks the whole zero-page store as zero through per-entry valid bits, so
// items are accepted right after reset. When the receiver stalls, the
// output register holds; once the input stage is full it holds too and
// s_axis_tready falls. No item is lost or repeated.
module cpu6502_subset_execute_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] opcode, [15:8] operand_low, [23:16] operand_high
	input  logic [c6502ex_pkg::IN_W-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] acc_value, [15:8] x_value, [23:16] y_value, [24] zero_flag,
	// [25] negative_flag, [41:26] next_pc, [43:42] write_kind,
	// [59:44] write_address, [75:60] write_data, [76] unsupported, rest zero
	output logic [c6502ex_pkg::OUT_W-1:0] m_axis_tdata
);

	import c6502ex_pkg::*;

	logic              in_accept;
	logic              s1_adv;
	logic              valid_s1;
	logic [BYTE_W-1:0] opcode_s1;
	logic [BYTE_W-1:0] operand_low_s1;
	logic [BYTE_W-1:0] operand_high_s1;
	arch_t             arch_q;
	arch_t             arch_nxt;
	exec_rpt_t         rpt;
	zp_wr_t            zp_wr;
	zp_wr_t            zp_wr_gated;
	logic [BYTE_W-1:0] zp_rdata;
	logic [BYTE_W-1:0] x_fwd;
	logic [BYTE_W-1:0] rd_index;
	logic [ZP_AW-1:0]  rd_addr;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// Handshake: the input stage moves whenever the output register frees up.
	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1       <= s_axis_tdata[7:0];
			operand_low_s1  <= s_axis_tdata[15:8];
			operand_high_s1 <= s_axis_tdata[23:16];
		end
	end

	// Zero-page read address, with X taken from the instruction now executing.
	assign x_fwd    = valid_s1 ? arch_nxt.x : arch_q.x;
	assign rd_index = (s_axis_tdata[7:0] == OP_LDA_ZPX) ? x_fwd : '0;
	assign rd_addr  = s_axis_tdata[15:8] + rd_index;

	always_comb begin
		zp_wr_gated    = zp_wr;
		zp_wr_gated.we = zp_wr.we && s1_adv;
	end

	c6502ex_zp_store u_zp_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_accept),
		.rd_addr(rd_addr),
		.wr     (zp_wr_gated),
		.rd_data(zp_rdata)
	);

	c6502ex_exec u_exec (
		.opcode      (opcode_s1),
		.operand_low (operand_low_s1),
		.operand_high(operand_high_s1),
		.cur         (arch_q),
		.zp_rdata    (zp_rdata),
		.nxt         (arch_nxt),
		.rpt         (rpt),
		.zp_wr       (zp_wr)
	);

	// Architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '{acc: '0, x: '0, y: '0, z: 1'b0, n: 1'b0, pc: PC_RESET};
		end else if (s1_adv) begin
			arch_q <= arch_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {3'b000, rpt.unsupported, rpt.write_data, rpt.write_address,
				rpt.write_kind, arch_nxt.pc, arch_nxt.n, arch_nxt.z,
				arch_nxt.y, arch_nxt.x, arch_nxt.acc};
		end
	end

endmodule

// ===== rtl/c6502ex_ram.sv =====
module c6502ex_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; read data holds without re.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/c6502ex_zp_store.sv =====
module c6502ex_zp_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [c6502ex_pkg::ZP_AW-1:0]  rd_addr,
	input  c6502ex_pkg::zp_wr_t         wr,
	output logic [c6502ex_pkg::BYTE_W-1:0] rd_data
);

	import c6502ex_pkg::*;

	logic [ZP_DEPTH-1:0] vld_q;
	logic [BYTE_W-1:0]   ram_rdata;
	logic                hit_s1;
	logic                vld_s1;
	logic [BYTE_W-1:0]   fwd_data_s1;

	c6502ex_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(ZP_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr.we),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.we) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	// A write landing in the same cycle as the read is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (rd_en) begin
			hit_s1 <= wr.we && (wr.addr == rd_addr);
			vld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= wr.data;
		end
	end

	// Resolve the read data.
	always_comb begin
		if (hit_s1) begin
			rd_data = fwd_data_s1;
		end else if (vld_s1) begin
			rd_data = ram_rdata;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ===== rtl/c6502ex_exec.sv =====
module c6502ex_exec (
	input  logic [c6502ex_pkg::BYTE_W-1:0] opcode,
	input  logic [c6502ex_pkg::BYTE_W-1:0] operand_low,
	input  logic [c6502ex_pkg::BYTE_W-1:0] operand_high,
	input  c6502ex_pkg::arch_t             cur,
	input  logic [c6502ex_pkg::BYTE_W-1:0] zp_rdata,
	output c6502ex_pkg::arch_t             nxt,
	output c6502ex_pkg::exec_rpt_t         rpt,
	output c6502ex_pkg::zp_wr_t            zp_wr
);

	import c6502ex_pkg::*;

	logic [WORD_W-1:0] abs_addr;
	logic [BYTE_W-1:0] zpx_addr;
	logic [BYTE_W-1:0] zpy_addr;
	logic [WORD_W-1:0] pc_base;
	logic [1:0]        len;
	logic              ld;
	logic [BYTE_W-1:0] ld_val;

	assign abs_addr = {operand_high, operand_low};
	assign zpx_addr = operand_low + cur.x;
	assign zpy_addr = operand_low + cur.y;

	// Decode and execute one instruction.
	always_comb begin
		nxt     = cur;
		rpt     = '0;
		pc_base = cur.pc;
		len     = 2'd2;
		ld      = 1'b0;
		ld_val  = '0;
		case (opcode)
			OP_AND_IMM: begin
				nxt.acc = cur.acc & operand_low;
				ld = 1'b1; ld_val = nxt.acc;
			end
			OP_LDA_IMM: begin
				nxt.acc = operand_low;
				ld = 1'b1; ld_val = nxt.acc;
			end
			OP_LDA_ZP, OP_LDA_ZPX: begin
				nxt.acc = zp_rdata;
				ld = 1'b1; ld_val = nxt.acc;
			end
			OP_LDX_IMM: begin
				nxt.x = operand_low;
				ld = 1'b1; ld_val = nxt.x;
			end
			OP_LDX_ZP: begin
				nxt.x = zp_rdata;
				ld = 1'b1; ld_val = nxt.x;
			end
			OP_LDY_IMM: begin
				nxt.y = operand_low;
				ld = 1'b1; ld_val = nxt.y;
			end
			OP_LDY_ZP: begin
				nxt.y = zp_rdata;
				ld = 1'b1; ld_val = nxt.y;
			end
			OP_NOP: begin
				len = 2'd1;
			end
			OP_STA_ZP: begin
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = {8'h00, operand_low};
				rpt.write_data    = {8'h00, cur.acc};
			end
			OP_STA_ZPX: begin
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = {8'h00, zpx_addr};
				rpt.write_data    = {8'h00, cur.acc};
			end
			OP_STX_ZP: begin
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = {8'h00, operand_low};
				rpt.write_data    = {8'h00, cur.x};
			end
			OP_STX_ZPY: begin
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = {8'h00, zpy_addr};
				rpt.write_data    = {8'h00, cur.x};
			end
			OP_STY_ZP: begin
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = {8'h00, operand_low};
				rpt.write_data    = {8'h00, cur.y};
			end
			OP_STY_ZPX: begin
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = {8'h00, zpx_addr};
				rpt.write_data    = {8'h00, cur.y};
			end
			OP_STX_ABS: begin
				len = 2'd3;
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = abs_addr;
				rpt.write_data    = {8'h00, cur.x};
			end
			OP_STY_ABS: begin
				len = 2'd3;
				rpt.write_kind    = WK_BYTE;
				rpt.write_address = abs_addr;
				rpt.write_data    = {8'h00, cur.y};
			end
			OP_JSR: begin
				// Push the return address minus one as a word and jump.
				len     = 2'd0;
				pc_base = abs_addr;
				rpt.write_kind    = WK_WORD;
				rpt.write_address = STACK_BASE;
				rpt.write_data    = cur.pc + 16'd2;
			end
			default: begin
				len = 2'd1;
				rpt.unsupported = 1'b1;
			end
		endcase
		if (ld) begin
			nxt.z = (ld_val == '0);
			nxt.n = ld_val[BYTE_W-1];
		end
		nxt.pc = pc_base + {14'd0, len};
	end

	// Only byte writes below 0x100 reach the zero-page store.
	always_comb begin
		zp_wr.we   = (rpt.write_kind == WK_BYTE) && (rpt.write_address[15:8] == 8'h00);
		zp_wr.addr = rpt.write_address[ZP_AW-1:0];
		zp_wr.data = rpt.write_data[BYTE_W-1:0];
	end

endmodule
